// ===== hdl/rpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfc_pkg
// Shared types and constants for the range position filter corrector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpfc_pkg;

    // Q8 millimetre positions; the gate margin is 20 mm
    localparam int POS_FRAC_BITS = 8;
    localparam logic signed [25:0] GATE_MARGIN_Q8 = 26'sd5120;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic signed [44:0] ROUND_HALF = 45'sd32768;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;

    typedef enum logic [2:0] {
        REG_CHECK_PERIOD = 3'd0,
        REG_EMA_ALPHA    = 3'd1,
        REG_THRESHOLD    = 3'd2,
        REG_OFFSET       = 3'd3,
        REG_BAR_LENGTH   = 3'd4,
        REG_AXIS_LENGTH  = 3'd5,
        REG_MOUNT        = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] check_period_ms;
        logic [15:0] ema_alpha_q16;
        logic [19:0] correct_threshold_q8;
        logic [19:0] sensor_offset_q8;
        logic [21:0] bar_length_q8;
        logic [21:0] axis_length_q8;
        logic        mount_far_end;
    } cfg_t;

    typedef struct packed {
        logic        clear_filter;
        logic [31:0] now_ms;
        logic        raw_valid;
        logic [23:0] raw_mm_q8;
        logic        axis_idle;
        logic        axis_homed;
        logic [24:0] stepper_pos_q8;   // signed
    } in_item_t;

    typedef struct packed {
        logic        sample_accepted;
        logic [24:0] filtered_pos_q8;  // signed
        logic        have_valid;
        logic [23:0] last_raw_q8;
        logic        adopt_position;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/rpfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rpfc_cfg_regs
// APB register file holding the filter and gate settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfc_cfg_regs
    import rpfc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_period_ms      <= 16'd50;
            cfg_reg.ema_alpha_q16        <= 16'd52429;
            cfg_reg.correct_threshold_q8 <= 20'd1280;
            cfg_reg.sensor_offset_q8     <= 20'd0;
            cfg_reg.bar_length_q8        <= 22'd153600;
            cfg_reg.axis_length_q8       <= 22'd153600;
            cfg_reg.mount_far_end        <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_CHECK_PERIOD: cfg_reg.check_period_ms      <= pwdata[15:0];
                REG_EMA_ALPHA:    cfg_reg.ema_alpha_q16        <= pwdata[15:0];
                REG_THRESHOLD:    cfg_reg.correct_threshold_q8 <= pwdata[19:0];
                REG_OFFSET:       cfg_reg.sensor_offset_q8     <= pwdata[19:0];
                REG_BAR_LENGTH:   cfg_reg.bar_length_q8        <= pwdata[21:0];
                REG_AXIS_LENGTH:  cfg_reg.axis_length_q8       <= pwdata[21:0];
                REG_MOUNT:        cfg_reg.mount_far_end        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CHECK_PERIOD: prdata = {16'd0, cfg_reg.check_period_ms};
            REG_EMA_ALPHA:    prdata = {16'd0, cfg_reg.ema_alpha_q16};
            REG_THRESHOLD:    prdata = {12'd0, cfg_reg.correct_threshold_q8};
            REG_OFFSET:       prdata = {12'd0, cfg_reg.sensor_offset_q8};
            REG_BAR_LENGTH:   prdata = {10'd0, cfg_reg.bar_length_q8};
            REG_AXIS_LENGTH:  prdata = {10'd0, cfg_reg.axis_length_q8};
            REG_MOUNT:        prdata = {31'd0, cfg_reg.mount_far_end};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/rpfc_filter.sv =====
// ----------------------------------------------------------------------------
// rpfc_filter
// Throttle, position conversion, range gate, EMA update and correction check.
// Holds the filter state; advances it on each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfc_filter
    import rpfc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [31:0]        last_check_reg, last_check_next;
    logic signed [24:0] filt_reg, filt_next;
    logic               seeded_reg, seeded_next;
    logic               valid_reg, valid_next;
    logic [23:0]        last_raw_reg, last_raw_next;

    logic [31:0]        elapsed;
    logic               checked;
    logic signed [25:0] pos_home, pos_far, pos;
    logic signed [25:0] gate_hi;
    logic               accept;
    logic [16:0]        weight;
    logic signed [26:0] diff;
    logic signed [44:0] prod, rounded;
    logic signed [28:0] ema_step, filt_sum;
    logic signed [24:0] filt_ema, filt_upd;
    logic signed [25:0] err, err_mag;
    logic               adopt;

    always_comb begin
        elapsed  = item.now_ms - last_check_reg;
        checked  = !item.clear_filter && (elapsed >= {16'd0, cfg.check_period_ms});

        pos_home = $signed({2'b00, item.raw_mm_q8}) - $signed({6'd0, cfg.sensor_offset_q8});
        pos_far  = $signed({4'd0, cfg.bar_length_q8}) - $signed({6'd0, cfg.sensor_offset_q8})
                 - $signed({2'b00, item.raw_mm_q8});
        pos      = cfg.mount_far_end ? pos_far : pos_home;

        gate_hi  = $signed({4'd0, cfg.axis_length_q8}) + GATE_MARGIN_Q8;
        accept   = checked && item.raw_valid && (pos >= -GATE_MARGIN_Q8) && (pos <= gate_hi);

        // f + round((1 - alpha) * (pos - f)), same as the weighted sum form
        weight   = ALPHA_ONE - {1'b0, cfg.ema_alpha_q16};
        diff     = {pos[25], pos} - {{2{filt_reg[24]}}, filt_reg};
        prod     = $signed({1'b0, weight}) * diff;
        rounded  = prod + ROUND_HALF;
        ema_step = $signed(rounded[44:16]);
        filt_sum = $signed({{4{filt_reg[24]}}, filt_reg}) + ema_step;
        filt_ema = filt_sum[24:0];
        filt_upd = seeded_reg ? filt_ema : pos[24:0];

        err      = $signed({filt_upd[24], filt_upd})
                 - $signed({item.stepper_pos_q8[24], item.stepper_pos_q8});
        err_mag  = err[25] ? -err : err;
        adopt    = accept && item.axis_idle && item.axis_homed
                 && ($unsigned(err_mag) > {6'd0, cfg.correct_threshold_q8});
    end

    always_comb begin
        last_check_next = last_check_reg;
        filt_next       = filt_reg;
        seeded_next     = seeded_reg;
        valid_next      = valid_reg;
        last_raw_next   = last_raw_reg;
        if (item.clear_filter) begin
            filt_next   = '0;
            seeded_next = 1'b0;
            valid_next  = 1'b0;
        end else if (checked) begin
            last_check_next = item.now_ms;
            if (item.raw_valid) begin
                last_raw_next = item.raw_mm_q8;
            end
            if (accept) begin
                filt_next   = filt_upd;
                seeded_next = 1'b1;
                valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_check_reg <= '0;
            filt_reg       <= '0;
            seeded_reg     <= 1'b0;
            valid_reg      <= 1'b0;
            last_raw_reg   <= '0;
        end else if (step_en) begin
            last_check_reg <= last_check_next;
            filt_reg       <= filt_next;
            seeded_reg     <= seeded_next;
            valid_reg      <= valid_next;
            last_raw_reg   <= last_raw_next;
        end
    end

    always_comb begin
        result.sample_accepted = accept;
        result.filtered_pos_q8 = filt_next;
        result.have_valid      = valid_next;
        result.last_raw_q8     = last_raw_next;
        result.adopt_position  = adopt;
    end

endmodule

`default_nettype wire

// ===== hdl/range_position_filter_corrector.sv =====
// ----------------------------------------------------------------------------
// range_position_filter_corrector
// Gated EMA of a range sensor position with stepper position correction.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata: loop word, s_tuser: clear_filter
//  m_       out  m_tvalid/m_tready  m_tdata: result word
//  apb      in   psel/penable       7 registers at byte address 4*index
//
//  One word per cycle sustained while m_tready is high. A word passes through
//  the input register, then the result register, before its result sits on
//  m_tdata; a stall can hold it in the input register. The filter state
//  update is combinational from its held registers, so consecutive words
//  never wait on each other.
//  Reset is synchronous: settings return to defaults, filter state clears.
//  A stalled result holds in the result register while the input register
//  still takes one more word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_position_filter_corrector
    import rpfc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // now_ms[31:0], raw_valid[32], raw_mm_q8[56:33], axis_idle[57],
    // axis_homed[58], stepper_pos_q8[83:59], zero pad[87:84]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // clear_filter[0]
    input  wire logic                 s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // sample_accepted[0], filtered_pos_q8[25:1], have_valid[26],
    // last_raw_q8[50:27], adopt_position[51], zero pad[55:52]
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      step_en;
    logic      s_fire;

    rpfc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpfc_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // advance when the input register holds a word and the result register is empty or being drained
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.clear_filter   <= s_tuser;
            in_item_reg.now_ms         <= s_tdata[31:0];
            in_item_reg.raw_valid      <= s_tdata[32];
            in_item_reg.raw_mm_q8      <= s_tdata[56:33];
            in_item_reg.axis_idle      <= s_tdata[57];
            in_item_reg.axis_homed     <= s_tdata[58];
            in_item_reg.stepper_pos_q8 <= s_tdata[83:59];
        end
        if (step_en) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_item_reg.adopt_position,
                       out_item_reg.last_raw_q8,
                       out_item_reg.have_valid,
                       out_item_reg.filtered_pos_q8,
                       out_item_reg.sample_accepted};

endmodule

`default_nettype wire
